// File: rtl/sfov_pkg.sv
package sfov_pkg;

	localparam int MapSide = 32;
	localparam int SideEff = (MapSide < 32) ? MapSide : 32;
	localparam int RowW = 5;
	localparam int StackDepth = 32;
	localparam int SpW = 6;

	typedef struct packed {
		logic        operation;
		logic [4:0]  row_index;
		logic [31:0] wall_bits;
		logic [4:0]  center_x;
		logic [4:0]  center_y;
		logic [5:0]  view_radius;
	} in_word_t;

	typedef struct packed {
		logic [4:0]  out_row;
		logic [31:0] visible_bits;
		logic        last;
	} out_word_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	// Slope numerators/denominators: odd values up to 2*63+1, plus 0 and 1.
	typedef logic signed [8:0] slope_t;

	// One scan frame (saved state of a suspended row loop).
	typedef struct packed {
		logic [6:0] row;      // current row i
		logic [6:0] dx_mag;   // -dx, next cell to resume at
		slope_t     sn;
		slope_t     sd;
		slope_t     en;
		slope_t     ed;
		slope_t     nn;
		slope_t     nd;
		logic       blocked;
		logic       row_end;  // every cell of the row done
	} frame_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_OCT,
		ST_ROW,
		ST_CELL,
		ST_VIS,
		ST_POP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic clear_row;
		logic oct_init;
		logic row_init;
		logic cell_eval;
		logic cell_commit;
		logic pop;
		logic out_emit;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic row_done;    // i > rad, or blocked at end of row
		logic cell_end;    // dx past zero or end slope reached: row finished
		logic descend;     // frame pushed, nested scan starts
		logic stack_empty;
		logic oct_last;
		logic out_last;
	} status_t;

	function automatic logic signed [1:0] oct_mul(input logic [2:0] k, input logic [1:0] j);
		logic signed [1:0] m [8][4];
		m[0] = '{2'sd1, 2'sd0, 2'sd0, 2'sd1};
		m[1] = '{2'sd0, 2'sd1, 2'sd1, 2'sd0};
		m[2] = '{-2'sd1, 2'sd0, 2'sd0, 2'sd1};
		m[3] = '{2'sd0, -2'sd1, 2'sd1, 2'sd0};
		m[4] = '{-2'sd1, 2'sd0, 2'sd0, -2'sd1};
		m[5] = '{2'sd0, -2'sd1, -2'sd1, 2'sd0};
		m[6] = '{2'sd1, 2'sd0, 2'sd0, -2'sd1};
		m[7] = '{2'sd0, 2'sd1, -2'sd1, 2'sd0};
		return m[k][j];
	endfunction

endpackage

// File: rtl/sfov_ctrl.sv
module sfov_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              operation,
	input  sfov_pkg::status_t stat,
	output sfov_pkg::cmd_t    cmd,
	output logic              busy
);

	sfov_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfov_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			sfov_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start && operation == sfov_pkg::OP_COMPUTE) begin
					state_d = sfov_pkg::ST_CLEAR;
				end
			end
			sfov_pkg::ST_CLEAR: begin
				cmd.clear_row = 1'b1;
				if (stat.clear_done) state_d = sfov_pkg::ST_OCT;
			end
			sfov_pkg::ST_OCT: begin
				cmd.oct_init = 1'b1;
				state_d = sfov_pkg::ST_ROW;
			end
			sfov_pkg::ST_ROW: begin
				if (stat.row_done) begin
					state_d = sfov_pkg::ST_POP;
				end else begin
					cmd.row_init = 1'b1;
					state_d = sfov_pkg::ST_CELL;
				end
			end
			sfov_pkg::ST_CELL: begin
				cmd.cell_eval = 1'b1;
				if (stat.cell_end) state_d = sfov_pkg::ST_ROW;
				else state_d = sfov_pkg::ST_VIS;
			end
			sfov_pkg::ST_VIS: begin
				cmd.cell_commit = 1'b1;
				if (stat.descend) state_d = sfov_pkg::ST_ROW;
				else state_d = sfov_pkg::ST_CELL;
			end
			sfov_pkg::ST_POP: begin
				cmd.pop = 1'b1;
				if (stat.stack_empty) begin
					state_d = stat.oct_last ? sfov_pkg::ST_OUT : sfov_pkg::ST_OCT;
				end else begin
					state_d = sfov_pkg::ST_CELL;
				end
			end
			sfov_pkg::ST_OUT: begin
				cmd.out_emit = 1'b1;
				if (stat.out_last) state_d = sfov_pkg::ST_IDLE;
			end
			default: state_d = sfov_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: rtl/sfov_datapath.sv
module sfov_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  sfov_pkg::in_word_t  in_word,
	input  sfov_pkg::cmd_t      cmd,
	output sfov_pkg::status_t   stat,
	output sfov_pkg::out_word_t result,
	output logic                result_valid
);

	logic [31:0] wall_q [sfov_pkg::SideEff];
	logic [31:0] vis_q [sfov_pkg::SideEff];
	sfov_pkg::frame_t stack_q [sfov_pkg::StackDepth];

	logic [4:0] cx_q, cy_q;
	logic [5:0] rad_q;
	logic [2:0] oct_q;
	logic [4:0] cnt_q;
	logic [sfov_pkg::SpW-1:0] sp_q;
	sfov_pkg::frame_t fr_q;

	// per-cell registered decision from the eval cycle
	logic       hit_s1;
	logic       wall_s1;
	logic [4:0] ax_s1, ay_s1;

	logic accept;
	assign accept = start && !busy;

	logic signed [1:0] m0, m1, m2, m3;
	assign m0 = sfov_pkg::oct_mul(oct_q, 2'd0);
	assign m1 = sfov_pkg::oct_mul(oct_q, 2'd1);
	assign m2 = sfov_pkg::oct_mul(oct_q, 2'd2);
	assign m3 = sfov_pkg::oct_mul(oct_q, 2'd3);

	// cell geometry: dx = -dx_mag, dy = -row
	logic signed [8:0] dxs, dys, lnv, ldv, rnv, rdv;
	logic signed [8:0] ax, ay;
	logic signed [17:0] p_rs, p_sr, p_le, p_el, p_sl, p_ls;
	logic skip, brk, on_map, wall_bit, child_abort;

	always_comb begin
		dxs = -$signed({2'b0, fr_q.dx_mag});
		dys = -$signed({2'b0, fr_q.row});
		lnv = 9'sd1 - (dxs <<< 1);
		ldv = ($signed({2'b0, fr_q.row}) <<< 1) - 9'sd1;
		rnv = -(dxs <<< 1) - 9'sd1;
		rdv = ($signed({2'b0, fr_q.row}) <<< 1) + 9'sd1;
		p_rs = rnv * fr_q.sd;
		p_sr = fr_q.sn * rdv;
		p_le = lnv * fr_q.ed;
		p_el = fr_q.en * ldv;
		// nested scan from this wall: start sn/sd, end ln/ld; empty if start < end
		p_sl = fr_q.sn * ldv;
		p_ls = lnv * fr_q.sd;
		skip = p_rs > p_sr;
		brk = p_le < p_el;
		child_abort = p_sl < p_ls;
		ax = $signed({4'b0, cx_q}) + dxs * m0 + dys * m1;
		ay = $signed({4'b0, cy_q}) + dxs * m2 + dys * m3;
		on_map = ax >= 0 && ay >= 0 && ax < sfov_pkg::SideEff && ay < sfov_pkg::SideEff;
		wall_bit = wall_q[ax[4:0]][ay[4:0]];
	end

	logic push_now;
	logic [4:0] top_idx;
	sfov_pkg::frame_t push_fr, child_fr;

	always_comb begin
		push_now = cmd.cell_commit && hit_s1 && !fr_q.blocked && wall_s1
		    && fr_q.row < {1'b0, rad_q} && int'(sp_q) < sfov_pkg::StackDepth
		    && !child_abort;
		// parent resumes blocked, at the next cell
		push_fr = fr_q;
		push_fr.blocked = 1'b1;
		push_fr.nn = rnv;
		push_fr.nd = rdv;
		if (fr_q.dx_mag == 7'd0) push_fr.row_end = 1'b1;
		else push_fr.dx_mag = fr_q.dx_mag - 7'd1;
		child_fr = '{row: fr_q.row + 7'd1, dx_mag: 7'd0, sn: fr_q.sn, sd: fr_q.sd,
		    en: lnv, ed: ldv, nn: fr_q.sn, nd: fr_q.sd, blocked: 1'b0, row_end: 1'b0};
		top_idx = sp_q[4:0] - 5'd1;
	end

	assign stat.clear_done = cnt_q == 5'(sfov_pkg::SideEff - 1);
	assign stat.out_last = cnt_q == 5'(sfov_pkg::SideEff - 1);
	assign stat.row_done = fr_q.blocked || fr_q.row > {1'b0, rad_q};
	assign stat.cell_end = fr_q.row_end || (brk && !skip);
	assign stat.descend = push_now;
	assign stat.stack_empty = sp_q == '0;
	assign stat.oct_last = oct_q == 3'd7;

	// frame stack, entries undefined until pushed
	always_ff @(posedge clk) begin
		if (push_now) stack_q[sp_q[4:0]] <= push_fr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sfov_pkg::SideEff; i++) begin
				wall_q[i] <= '0;
				vis_q[i] <= '0;
			end
			cx_q <= '0;
			cy_q <= '0;
			rad_q <= '0;
			sp_q <= '0;
			cnt_q <= '0;
			oct_q <= '0;
			fr_q <= '0;
			hit_s1 <= 1'b0;
			wall_s1 <= 1'b0;
			ax_s1 <= '0;
			ay_s1 <= '0;
			result <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.out_emit;
			hit_s1 <= cmd.cell_eval && !stat.cell_end && !skip && on_map;
			if (cmd.cell_eval) begin
				wall_s1 <= wall_bit;
				ax_s1 <= ax[4:0];
				ay_s1 <= ay[4:0];
			end
			if (accept) begin
				if (in_word.operation == sfov_pkg::OP_WRITE) begin
					if (32'(in_word.row_index) < sfov_pkg::SideEff)
						wall_q[in_word.row_index] <= in_word.wall_bits;
				end else begin
					cx_q <= in_word.center_x;
					cy_q <= in_word.center_y;
					rad_q <= in_word.view_radius;
					cnt_q <= '0;
					oct_q <= '0;
				end
			end
			if (cmd.clear_row) begin
				vis_q[cnt_q] <= (32'(cx_q) < sfov_pkg::SideEff && 32'(cy_q) <
				    sfov_pkg::SideEff && cnt_q == cx_q) ? (32'd1 << cy_q) : '0;
				cnt_q <= stat.clear_done ? 5'd0 : cnt_q + 5'd1;
			end
			if (cmd.oct_init) begin
				fr_q <= '{row: 7'd1, dx_mag: 7'd0, sn: 9'sd1, sd: 9'sd1, en: 9'sd0,
				    ed: 9'sd1, nn: 9'sd1, nd: 9'sd1, blocked: 1'b0, row_end: 1'b0};
			end
			if (cmd.row_init) begin
				fr_q.dx_mag <= fr_q.row;
				fr_q.nn <= fr_q.sn;
				fr_q.nd <= fr_q.sd;
				fr_q.blocked <= 1'b0;
				fr_q.row_end <= 1'b0;
			end
			// row finished: next row, blocked kept for the row_done check
			if (cmd.cell_eval && stat.cell_end) fr_q.row <= fr_q.row + 7'd1;
			if (cmd.cell_commit) begin
				if (hit_s1) vis_q[ax_s1][ay_s1] <= 1'b1;
				if (push_now) begin
					// suspend this frame and descend
					sp_q <= sp_q + 6'd1;
					fr_q <= child_fr;
				end else begin
					if (hit_s1) begin
						if (fr_q.blocked) begin
							if (wall_s1) begin
								fr_q.nn <= rnv;
								fr_q.nd <= rdv;
							end else begin
								fr_q.blocked <= 1'b0;
								fr_q.sn <= fr_q.nn;
								fr_q.sd <= fr_q.nd;
							end
						end else if (wall_s1 && fr_q.row < {1'b0, rad_q}) begin
							// nested scan empty or stack full
							fr_q.blocked <= 1'b1;
							fr_q.nn <= rnv;
							fr_q.nd <= rdv;
						end
					end
					if (fr_q.dx_mag == 7'd0) fr_q.row_end <= 1'b1;
					else fr_q.dx_mag <= fr_q.dx_mag - 7'd1;
				end
			end
			if (cmd.pop) begin
				if (sp_q == '0) begin
					oct_q <= oct_q + 3'd1;
				end else begin
					fr_q <= stack_q[top_idx];
					sp_q <= sp_q - 6'd1;
				end
			end
			if (cmd.out_emit) begin
				result <= '{out_row: cnt_q, visible_bits: vis_q[cnt_q],
				    last: stat.out_last};
				cnt_q <= stat.out_last ? 5'd0 : cnt_q + 5'd1;
			end
		end
	end

endmodule

// File: rtl/shadowcast_field_of_view.sv
// Shadowcasting field of view over a 32x32 wall map.
// Command port: a word is taken at a rising edge with start high and busy low.
//   operation 0 writes wall_bits into wall row row_index with no result,
//   and the next word can follow on the very next edge.
//   operation 1 computes visibility around (center_x, center_y) out to the
//   Chebyshev radius view_radius, then streams 32 row words on result with
//   done high for one cycle each; the final row carries last.
// A compute first clears the visibility map row by row, then for each octant
// scans the rows i up to the radius, evaluating and then committing each cell
// (off-map cells included) in a single-cell scan unit. Every wall that opens
// a shadow adds a nested scan that walks its rows again from the near edge.
// Then the row words are streamed out. One compute at a time.
// busy rises after a compute word is taken and drops in the cycle that
// carries the last row word. Nested scans live on a 32-entry frame stack.
// Reset (arst_n low) clears the wall map to open floor, the visibility map,
// the stack pointer and the controller. The receiver cannot stall: each
// result word is valid for exactly one cycle.
module shadowcast_field_of_view (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  sfov_pkg::in_word_t  cmd_word,
	output logic                busy,
	output logic                done,
	output sfov_pkg::out_word_t result
);

	sfov_pkg::cmd_t    cmd;
	sfov_pkg::status_t stat;

	sfov_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start),
		.operation(cmd_word.operation), .stat(stat), .cmd(cmd), .busy(busy)
	);

	sfov_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.in_word(cmd_word), .cmd(cmd), .stat(stat),
		.result(result), .result_valid(done)
	);

	a_no_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last |-> busy) else $error("row word outside compute");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.last |=> !done) else $error("word after last");

endmodule
